// ===== design/mkte_pkg.sv =====
package mkte_pkg;

	localparam int ROW_COUNT = 3;

	typedef enum logic [1:0] {
		OP_KEY     = 2'd0,
		OP_WHEEL   = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		KEY_ROW   = 3'd0,
		KEY_B1    = 3'd1,
		KEY_B2    = 3'd2,
		KEY_B3    = 3'd3,
		KEY_LEFT  = 3'd4,
		KEY_RIGHT = 3'd5,
		KEY_EXIT  = 3'd6,
		KEY_NONE  = 3'd7
	} key_act_t;

	typedef enum logic {
		KIND_CHAR   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	localparam logic CFG_NUMERIC_MODE = 1'b0;
	localparam logic CFG_THIRD_GEN    = 1'b1;

	localparam logic [7:0] KC_W  = 8'h77;
	localparam logic [7:0] KC_L  = 8'h6C;
	localparam logic [7:0] KC_R  = 8'h72;
	localparam logic [7:0] KC_M  = 8'h6D;
	localparam logic [7:0] KC_D  = 8'h64;
	localparam logic [7:0] KC_F  = 8'h66;
	localparam logic [7:0] KC_CR = 8'h0D;
	localparam logic [7:0] KC_LF = 8'h0A;

	localparam logic [7:0] CHAR_LEFT  = 8'd28;
	localparam logic [7:0] CHAR_RIGHT = 8'd29;

	localparam logic [3:0] LAST_BUTTON = 4'd8;

	localparam logic [0:15][7:0] LETTER_SYM [9] = '{
		'{8'h20, 8'h08, 8'h2E, 8'h2C, 8'h31, 8'h30, 8'h21, 8'h3F,
		  8'h0A, 8'h3A, 8'h3B, 8'h22, 8'h27, 8'hA1, 8'hBF, 8'h00},
		'{8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h43, 8'h32, 8'h40,
		  8'h2F, 8'h5C, 8'h5F, 8'h7C, 8'hA6, 8'h00, 8'h00, 8'h00},
		'{8'h64, 8'h65, 8'h66, 8'h44, 8'h45, 8'h46, 8'h33, 8'h23,
		  8'hBA, 8'hAA, 8'hB9, 8'hB2, 8'hB3, 8'h00, 8'h00, 8'h00},
		'{8'h67, 8'h68, 8'h69, 8'h47, 8'h48, 8'h49, 8'h34, 8'h24,
		  8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6A, 8'h6B, 8'h6C, 8'h4A, 8'h4B, 8'h4C, 8'h35, 8'h25,
		  8'hBC, 8'hBD, 8'hBE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6D, 8'h6E, 8'h6F, 8'h4D, 8'h4E, 8'h4F, 8'h36, 8'h5E,
		  8'h7E, 8'h60, 8'hB4, 8'hA8, 8'hB8, 8'h00, 8'h00, 8'h00},
		'{8'h70, 8'h71, 8'h72, 8'h73, 8'h50, 8'h51, 8'h52, 8'h53,
		  8'h37, 8'h26, 8'hA7, 8'hB6, 8'hB0, 8'hA9, 8'hAE, 8'hB5},
		'{8'h74, 8'h75, 8'h76, 8'h54, 8'h55, 8'h56, 8'h38, 8'h2A,
		  8'h2B, 8'h2D, 8'h3D, 8'h3C, 8'h3E, 8'h00, 8'h00, 8'h00},
		'{8'h77, 8'h78, 8'h79, 8'h7A, 8'h57, 8'h58, 8'h59, 8'h5A,
		  8'h39, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h00}
	};

	localparam logic [4:0] LETTER_LEN [9] = '{
		5'd15, 5'd13, 5'd13, 5'd12, 5'd11, 5'd13, 5'd16, 5'd13, 5'd15
	};

	localparam logic [4:0] NUM_ZERO_LEN = 5'd11;

	localparam logic [0:15][7:0] NUM_ZERO = '{
		8'h31, 8'h30, 8'h2E, 8'h2D, 8'h08, 8'h45, 8'h2B, 8'h2D,
		8'h2A, 8'h2F, 8'h5E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] NUM_DIGIT [9] = '{
		8'h00, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39
	};

	localparam logic [3:0] WHEEL_BTN [8] = '{
		4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0
	};

	typedef struct packed {
		logic numeric_mode;
		logic third_gen_layout;
	} cfg_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [7:0]  key_char;
		logic [2:0]  wheel_position;
	} in_item_t;

	typedef struct packed {
		logic [1:0] row;
		logic [3:0] btn;
		logic [4:0] sym;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_code;
		logic        exit_request;
		logic        restart_timer;
		logic        pending_valid;
		logic [7:0]  pending_char;
		logic [1:0]  row;
		logic        last;
	} res_t;

	function automatic logic [4:0] sym_len(input logic [3:0] btn, input logic numeric);
		logic [4:0] len;
		if (btn > LAST_BUTTON) begin
			len = 5'd1;
		end else if (numeric) begin
			len = (btn == 4'd0) ? NUM_ZERO_LEN : 5'd1;
		end else begin
			len = LETTER_LEN[btn];
		end
		return len;
	endfunction

	function automatic logic [7:0] sym_at(input logic [3:0] btn, input logic [4:0] idx,
			input logic numeric);
		logic [4:0] len;
		logic [4:0] k;
		logic [3:0] k0;
		logic [7:0] c;
		len = sym_len(btn, numeric);
		k = idx;
		if (k == 5'd0) begin
			k = 5'd1;
		end
		if (k > len) begin
			k = len;
		end
		k0 = 4'(k - 5'd1);
		if (btn > LAST_BUTTON) begin
			c = 8'h00;
		end else if (numeric) begin
			c = (btn == 4'd0) ? NUM_ZERO[k0] : NUM_DIGIT[btn];
		end else begin
			c = LETTER_SYM[btn][k0];
		end
		return c;
	endfunction

	function automatic key_act_t map_key(input logic [7:0] c, input logic third_gen);
		key_act_t a;
		logic crlf;
		crlf = (c == KC_CR) || (c == KC_LF);
		a = KEY_NONE;
		if (c == KC_W) begin
			a = KEY_B1;
		end else if (c == KC_L) begin
			a = KEY_LEFT;
		end else if (c == KC_R) begin
			a = KEY_RIGHT;
		end else if (third_gen) begin
			if (c == KC_M) a = KEY_B2;
			else if (c == KC_D) a = KEY_B3;
			else if (c == KC_F) a = KEY_ROW;
			else if (crlf) a = KEY_EXIT;
		end else begin
			if (crlf) a = KEY_B2;
			else if (c == KC_F) a = KEY_B3;
			else if (c == KC_D) a = KEY_ROW;
			else if (c == KC_M) a = KEY_EXIT;
		end
		return a;
	endfunction

endpackage

// ===== design/mkte_step.sv =====
module mkte_step
	import mkte_pkg::*;
(
	input  in_item_t   item,
	input  state_t     st,
	input  cfg_t       cfg,
	output state_t     st_n,
	output res_t       res [3],
	output logic [1:0] n_res
);

	key_act_t   kact;
	logic [3:0] pb;
	logic       do_press;
	logic       do_commit;
	logic       row_adv;
	logic       exitr;
	logic       restart;
	logic       has_pend;
	logic [7:0] pend_c;
	logic [7:0] new_c;
	logic [1:0] n_ch;
	logic [7:0] c0;
	logic [7:0] c1;
	logic [2:0] row_inc;
	logic [5:0] sym_inc;
	res_t       status;

	assign kact     = map_key(item.key_char, cfg.third_gen_layout);
	assign has_pend = (st.sym != 5'd0);
	assign pend_c   = sym_at(st.btn, st.sym, cfg.numeric_mode);
	assign new_c    = sym_at(pb, 5'd1, cfg.numeric_mode);
	assign row_inc  = {1'b0, st.row} + 3'd1;
	assign sym_inc  = {1'b0, st.sym} + 6'd1;

	always_comb begin
		do_press  = 1'b0;
		do_commit = 1'b0;
		row_adv   = 1'b0;
		exitr     = 1'b0;
		restart   = 1'b0;
		pb        = 4'd0;
		n_ch      = 2'd0;
		c0        = 8'h00;
		c1        = 8'h00;
		st_n      = st;
		case (item.opcode)
			OP_KEY: begin
				restart = 1'b1;
				case (kact)
					KEY_ROW: begin
						do_commit = 1'b1;
						row_adv   = 1'b1;
					end
					KEY_B1, KEY_B2, KEY_B3: begin
						do_press = 1'b1;
						pb = 4'({2'b00, st.row} * 4'd3 + {1'b0, kact} - 4'd1);
					end
					KEY_LEFT: begin
						n_ch = 2'd1;
						c0   = CHAR_LEFT;
					end
					KEY_RIGHT: begin
						n_ch = 2'd1;
						c0   = CHAR_RIGHT;
					end
					KEY_EXIT: exitr = 1'b1;
					KEY_NONE: ;
					default: ;
				endcase
			end
			OP_WHEEL: begin
				restart  = 1'b1;
				do_press = 1'b1;
				pb       = WHEEL_BTN[item.wheel_position];
			end
			OP_TIMEOUT: do_commit = 1'b1;
			OP_CLEAR: st_n = '0;
			default: ;
		endcase

		if (do_commit) begin
			if (has_pend) begin
				n_ch = 2'd1;
				c0   = pend_c;
			end
			st_n.sym = 5'd0;
		end
		if (row_adv) begin
			st_n.row = (row_inc >= 3'(ROW_COUNT)) ? 2'd0 : row_inc[1:0];
		end
		if (do_press) begin
			if (pb != 4'd0 && cfg.numeric_mode) begin
				if (has_pend) begin
					n_ch = 2'd2;
					c0   = pend_c;
					c1   = new_c;
				end else begin
					n_ch = 2'd1;
					c0   = new_c;
				end
				st_n.btn = pb;
				st_n.sym = 5'd0;
			end else if (pb == st.btn) begin
				st_n.sym = (sym_inc > {1'b0, sym_len(st.btn, cfg.numeric_mode)}) ?
					5'd1 : sym_inc[4:0];
			end else begin
				if (has_pend) begin
					n_ch = 2'd1;
					c0   = pend_c;
				end
				st_n.btn = pb;
				st_n.sym = 5'd1;
			end
		end
	end

	always_comb begin
		status               = '0;
		status.kind          = KIND_STATUS;
		status.exit_request  = exitr;
		status.restart_timer = restart;
		status.pending_valid = (st_n.sym != 5'd0);
		status.pending_char  = (st_n.sym != 5'd0) ?
			sym_at(st_n.btn, st_n.sym, cfg.numeric_mode) : 8'h00;
		status.row           = st_n.row;
		status.last          = 1'b1;
	end

	always_comb begin
		res[0] = '0;
		res[1] = '0;
		res[2] = '0;
		res[0].kind = KIND_CHAR;
		res[1].kind = KIND_CHAR;
		res[2].kind = KIND_CHAR;
		res[0].char_code = c0;
		res[1].char_code = c1;
		case (n_ch)
			2'd0: res[0] = status;
			2'd1: res[1] = status;
			2'd2: res[2] = status;
			default: res[2] = status;
		endcase
		n_res = n_ch + 2'd1;
	end

endmodule

// ===== design/mkte_obuf.sv =====
module mkte_obuf
	import mkte_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       load_items [3],
	input  logic [1:0] load_cnt,
	input  logic       out_ready,
	output logic       out_valid,
	output res_t       out_item,
	output logic       can_load
);

	res_t       slot_q [3];
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot_q[0];
	assign pop       = out_valid && out_ready;
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q[0] <= load_items[0];
			slot_q[1] <= load_items[1];
			slot_q[2] <= load_items[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

// ===== design/multitap_keypad_text_entry.sv =====
// channel  dir  handshake                 payload
// s        in   s_tvalid / s_tready       s_tdata key_char, wheel_position; s_tuser opcode
// m        out  m_tvalid / m_tready       m_tdata char and status fields; m_tuser kind; m_tlast
// cfg      in   cfg_valid / cfg_ready     cfg_index register, cfg_data value
//
// an item is held in the input register, worked out in one pass and loaded into a
// three-slot result buffer; results leave one per cycle while m_tready is high, and
// the next item is loaded once the buffer is empty or passing on its last result
// arst_n clears keypad state, configuration and all valid flags
// m_tready low holds the buffer; s_tready drops once the input register is full
// and the buffer cannot take its results
module multitap_keypad_text_entry
	import mkte_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // key_char[7:0], wheel_position[10:8], zero
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // char_code[7:0], exit_request[8], restart_timer[9],
	                               // pending_valid[10], pending_char[18:11], row[20:19], zero
	output logic        m_tuser,   // kind[0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	cfg_t       cfg_q;
	state_t     st_q;
	state_t     st_n;
	logic       valid_s1;
	in_item_t   item_s1;
	logic       take;
	logic       can_load;
	res_t       step_res [3];
	logic [1:0] step_n;
	res_t       out_item;

	assign cfg_ready = 1'b1;
	assign take      = valid_s1 && can_load;
	assign s_tready  = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUMERIC_MODE: cfg_q.numeric_mode     <= cfg_data;
				CFG_THIRD_GEN:    cfg_q.third_gen_layout <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode         <= opcode_t'(s_tuser);
			item_s1.key_char       <= s_tdata[7:0];
			item_s1.wheel_position <= s_tdata[10:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= st_n;
		end
	end

	mkte_step u_step (
		.item  (item_s1),
		.st    (st_q),
		.cfg   (cfg_q),
		.st_n  (st_n),
		.res   (step_res),
		.n_res (step_n)
	);

	mkte_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.load_items (step_res),
		.load_cnt   (step_n),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_item   (out_item),
		.can_load   (can_load)
	);

	assign m_tdata = {3'b000, out_item.row, out_item.pending_char, out_item.pending_valid,
		out_item.restart_timer, out_item.exit_request, out_item.char_code};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("last flag and status kind disagree");

	a_char_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[23:8] == 16'h0000))
		else $error("character transfer carries status fields");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.btn <= LAST_BUTTON) && ({1'b0, st_q.row} < 3'(ROW_COUNT)))
		else $error("keypad state out of range");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take) |=> (valid_s1 && $stable(item_s1)))
		else $error("held item lost before its results were loaded");

endmodule

// ===== tb/sv/tb_multitap_keypad_text_entry.sv =====
`timescale 1ns / 1ps

module tb_multitap_keypad_text_entry;
	import mkte_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	// symbol strings per button, first symbol in the leftmost byte
	localparam logic [0:15][7:0] LETTER_TABLE [9] = '{
		128'h20082E2C3130213F_0A3A3B2227A1BF00,
		128'h6162634142433240_2F5C5F7CA6000000,
		128'h6465664445463323_BAAAB9B2B3000000,
		128'h6768694748493424_A2A3A4A500000000,
		128'h6A6B6C4A4B4C3525_BCBDBE0000000000,
		128'h6D6E6F4D4E4F365E_7E60B4A8B8000000,
		128'h7071727350515253_3726A7B6B0A9AEB5,
		128'h747576545556382A_2B2D3D3C3E000000,
		128'h7778797A5758595A_3928295B5D7B7D00
	};
	localparam logic [4:0] LETTER_COUNT [9] = '{
		5'd15, 5'd13, 5'd13, 5'd12, 5'd11, 5'd13, 5'd16, 5'd13, 5'd15
	};
	localparam logic [0:10][7:0] NUMERIC_ZERO = 88'h31302E2D08452B2D2A2F5E;
	localparam logic [3:0] OCTANT_BUTTON [8] = '{
		4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic        cfg_data;

	// keypad state and settings as seen by the predictor
	logic        cfg_numeric;
	logic        cfg_alt_layout;
	logic [1:0]  kp_row;
	logic [3:0]  kp_btn;
	logic [4:0]  kp_sym;
	int          chars_out;

	res_t        results_due[$];
	int          errors;
	int          quiet_cycles;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          rx_hold_len;

	multitap_keypad_text_entry uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [4:0] symbols_on(logic [3:0] b);
		if (b > 4'd8) return 5'd1;
		if (cfg_numeric) return (b == 4'd0) ? 5'd11 : 5'd1;
		return LETTER_COUNT[b];
	endfunction

	function automatic logic [7:0] symbol_of(logic [3:0] b, logic [4:0] idx);
		logic [4:0] n;
		logic [4:0] k;
		n = symbols_on(b);
		k = idx;
		if (b > 4'd8) return 8'h00;
		if (k < 5'd1) k = 5'd1;
		if (k > n) k = n;
		if (cfg_numeric) return (b == 4'd0) ? NUMERIC_ZERO[k - 5'd1] : 8'h31 + 8'(b);
		return LETTER_TABLE[b][k - 5'd1];
	endfunction

	function automatic key_act_t key_action(logic [7:0] c);
		logic crlf;
		crlf = (c == KC_CR) || (c == KC_LF);
		if (c == KC_W) return KEY_B1;
		if (c == KC_L) return KEY_LEFT;
		if (c == KC_R) return KEY_RIGHT;
		if (cfg_alt_layout) begin
			if (c == KC_M) return KEY_B2;
			if (c == KC_D) return KEY_B3;
			if (c == KC_F) return KEY_ROW;
			if (crlf) return KEY_EXIT;
		end else begin
			if (crlf) return KEY_B2;
			if (c == KC_F) return KEY_B3;
			if (c == KC_D) return KEY_ROW;
			if (c == KC_M) return KEY_EXIT;
		end
		return KEY_NONE;
	endfunction

	function automatic void emit_symbol(logic [7:0] c);
		res_t r;
		if (chars_out >= 2) return;
		r = '0;
		r.kind = KIND_CHAR;
		r.char_code = c;
		results_due.push_back(r);
		chars_out++;
	endfunction

	function automatic void commit_pending_symbol();
		if (kp_sym != 5'd0) emit_symbol(symbol_of(kp_btn, kp_sym));
		kp_sym = 5'd0;
	endfunction

	function automatic void press_button(logic [3:0] b);
		if (b != 4'd0 && cfg_numeric) begin
			commit_pending_symbol();
			kp_btn = b;
			kp_sym = 5'd1;
			commit_pending_symbol();
		end else if (b == kp_btn) begin
			kp_sym++;
			if (kp_sym > symbols_on(kp_btn)) kp_sym = 5'd1;
		end else begin
			commit_pending_symbol();
			kp_btn = b;
			kp_sym = 5'd1;
		end
	endfunction

	function automatic void predict_keypad_entry(opcode_t op, logic [7:0] key, logic [2:0] wheel);
		res_t st;
		key_act_t act;
		logic exit_req;
		logic restart;
		chars_out = 0;
		exit_req = 1'b0;
		restart = 1'b0;
		case (op)
			OP_KEY: begin
				restart = 1'b1;
				act = key_action(key);
				case (act)
					KEY_ROW: begin
						commit_pending_symbol();
						if (int'(kp_row) + 1 >= ROW_COUNT) kp_row = 2'd0;
						else kp_row++;
					end
					KEY_LEFT: emit_symbol(CHAR_LEFT);
					KEY_RIGHT: emit_symbol(CHAR_RIGHT);
					KEY_EXIT: exit_req = 1'b1;
					KEY_NONE: ;
					default: press_button(4'(int'(kp_row) * 3 + int'(act) - 1));
				endcase
			end
			OP_WHEEL: begin
				restart = 1'b1;
				press_button(OCTANT_BUTTON[wheel]);
			end
			OP_TIMEOUT: commit_pending_symbol();
			default: begin
				kp_row = 2'd0;
				kp_btn = 4'd0;
				kp_sym = 5'd0;
			end
		endcase
		st = '0;
		st.kind = KIND_STATUS;
		st.exit_request = exit_req;
		st.restart_timer = restart;
		st.pending_valid = (kp_sym != 5'd0);
		st.pending_char = (kp_sym != 5'd0) ? symbol_of(kp_btn, kp_sym) : 8'h00;
		st.row = kp_row;
		st.last = 1'b1;
		results_due.push_back(st);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// result checker and watchdog
	always @(negedge clk) begin
		res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t unexpected transfer: expected none actual tdata %h tuser %b tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = results_due.pop_front();
					check_field("kind", 8'(want.kind), 8'(m_tuser));
					check_field("char_code", want.char_code, m_tdata[7:0]);
					check_field("exit_request", 8'(want.exit_request), 8'(m_tdata[8]));
					check_field("restart_timer", 8'(want.restart_timer), 8'(m_tdata[9]));
					check_field("pending_valid", 8'(want.pending_valid), 8'(m_tdata[10]));
					check_field("pending_char", want.pending_char, m_tdata[18:11]);
					check_field("row", 8'(want.row), 8'(m_tdata[20:19]));
					check_field("last", 8'(want.last), 8'(m_tlast));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t timeout, %0d results outstanding", $time, results_due.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// result receiver
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
				m_tready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_entry(opcode_t op, logic [7:0] key, logic [2:0] wheel);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, wheel, key};
		s_tuser <= op;
		do @(negedge clk); while (!s_tready);
		predict_keypad_entry(op, key, wheel);
		@(posedge clk);
	endtask

	task automatic send_key(logic [7:0] key);
		send_entry(OP_KEY, key, 3'($urandom));
	endtask

	task automatic send_octant(logic [2:0] wheel);
		send_entry(OP_WHEEL, 8'($urandom), wheel);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		if (idx == CFG_NUMERIC_MODE) cfg_numeric = val;
		else cfg_alt_layout = val;
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic numeric, logic alt_layout);
		wait_idle();
		write_reg(CFG_NUMERIC_MODE, numeric);
		write_reg(CFG_THIRD_GEN, alt_layout);
	endtask

	task automatic reset_block();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_KEY;
		cfg_valid = 1'b0;
		cfg_index = CFG_NUMERIC_MODE;
		cfg_data = 1'b0;
		cfg_numeric = 1'b0;
		cfg_alt_layout = 1'b0;
		kp_row = '0;
		kp_btn = '0;
		kp_sym = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// letters, first layout: cycling, commits, row switch, cursor, exit, unmapped bytes
	task automatic test_directed_keys();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_key(KC_W);
		send_key(KC_W);
		send_key(KC_W);
		send_key(KC_CR);
		send_key(KC_LF);
		send_key(KC_F);
		send_key(KC_D);
		send_key(KC_W);
		send_key(KC_L);
		send_key(KC_R);
		send_key(KC_M);
		send_key(8'h00);
		send_key(8'hFF);
		send_entry(OP_TIMEOUT, 8'hFF, 3'd7);
		send_entry(OP_CLEAR, 8'h00, 3'd0);
	endtask

	task automatic test_wheel_octants();
		for (int w = 0; w < 8; w++) send_octant(3'(w));
	endtask

	// pending index beyond the numeric string end after a mode change
	task automatic test_mode_switch();
		send_entry(OP_CLEAR, 8'($urandom), 3'($urandom));
		repeat (12) send_octant(3'd7);
		set_config(1'b1, 1'b0);
		send_key(8'h00);
		send_octant(3'd7);
		send_octant(3'd0);
		send_entry(OP_TIMEOUT, 8'($urandom), 3'($urandom));
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_len = 250;
		send_octant(3'd7);
		send_key(KC_W);
		repeat (10) send_octant(3'($urandom));
		wait_idle();
	endtask

	task automatic test_random_phases();
		logic [1:0] phase_cfg [7] = '{2'b00, 2'b11, 2'b01, 2'b10, 2'b11, 2'b10, 2'b00};
		logic [7:0] mapped [8] = '{KC_W, KC_CR, KC_LF, KC_F, KC_D, KC_M, KC_L, KC_R};
		int sent;
		int reps;
		int r;
		opcode_t op;
		logic [7:0] key;
		logic [2:0] wheel;
		for (int p = 0; p < 7; p++) begin
			tx_idle_on = (p < 6) && ($urandom_range(0, 2) != 0);
			rx_idle_on = (p < 6) && ($urandom_range(0, 2) != 0);
			set_config(phase_cfg[p][1], phase_cfg[p][0]);
			sent = 0;
			while (sent < 40) begin
				r = $urandom_range(0, 99);
				key = 8'($urandom);
				wheel = 3'($urandom);
				if (r < 55) begin
					op = OP_KEY;
					key = mapped[$urandom_range(0, 7)];
				end else if (r < 78) begin
					op = OP_WHEEL;
				end else if (r < 88) begin
					op = OP_TIMEOUT;
				end else if (r < 93) begin
					op = OP_CLEAR;
				end else begin
					op = OP_KEY;
				end
				reps = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 17) : $urandom_range(1, 3);
				repeat (reps) begin
					send_entry(op, key, wheel);
					sent++;
				end
			end
		end
	endtask

	initial begin
		errors = 0;
		quiet_cycles = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_len = 0;
		reset_block();
		test_directed_keys();
		test_wheel_octants();
		test_mode_switch();
		test_backpressure();
		test_random_phases();
		wait_idle();
		repeat (10) @(posedge clk);
		if (results_due.size() != 0)
			$display("%0t %0d expected results never arrived", $time, results_due.size());
		if (errors == 0 && results_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
